/* rtl/bss_pkg.sv */
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and constants for the batch sorter with swap counter.
// ----------------------------------------------------------------------------
package bss_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int VALUE_W   = 32;
	localparam int SWAP_W    = 11;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT,
		ST_FLUSH,
		ST_EMIT
	} st_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // input transaction accepted
		logic sort;   // run one odd-even phase this cycle
		logic shift;  // output transaction accepted
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sort_done;  // current phase is the final one
		logic one_left;   // exactly one sorted element remains
	} sts_t;

endpackage

/* rtl/bubble_sort_swap_counter.sv */
// ----------------------------------------------------------------------------
// bubble_sort_swap_counter
// Batch sorter: collects signed values, sorts them ascending and reports
// the number of adjacent swaps (inversions) of the batch.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (valid, stall, value, last) takes one element per
// transaction, one per cycle while loading. A transaction with last set
// ends the batch. Elements beyond DEPTH are dropped and set overflow.
// Once last is taken, stall stays high while the batch of n elements is
// sorted by an odd-even transposition network in n phases, after which
// the flush state finishes the swap count. The results then leave on the
// output channel (valid_res, stall_res, value_res, last_res, swap_count,
// overflow), one per cycle, smallest first; last_res marks the final one,
// and swap_count and overflow are the same on every result of the batch.
// A stall on the output holds the current result and pauses the batch; no
// new input is taken until the final result has left. Reset empties the
// block and returns it to loading.
// ----------------------------------------------------------------------------
module bubble_sort_swap_counter #(
	parameter int DEPTH = bss_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               valid,
	output logic                               stall,
	input  logic signed [bss_pkg::VALUE_W-1:0] value,
	input  logic                               last,
	output logic                               valid_res,
	input  logic                               stall_res,
	output logic signed [bss_pkg::VALUE_W-1:0] value_res,
	output logic                               last_res,
	output logic [bss_pkg::SWAP_W-1:0]         swap_count,
	output logic                               overflow
);
	import bss_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid),
		.last      (last),
		.stall_res (stall_res),
		.sts       (sts),
		.stall     (stall),
		.valid_res (valid_res),
		.cmd       (cmd)
	);

	bss_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.value      (value),
		.sts        (sts),
		.value_res  (value_res),
		.last_res   (last_res),
		.swap_count (swap_count),
		.overflow   (overflow)
	);

endmodule

/* rtl/bss_datapath.sv */
// ----------------------------------------------------------------------------
// bss_datapath
// Element lanes, fill and phase counters, odd-even compare-exchange network
// and swap accumulator.
// ----------------------------------------------------------------------------
module bss_datapath #(
	parameter int DEPTH = bss_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bss_pkg::cmd_t                      cmd,
	input  logic signed [bss_pkg::VALUE_W-1:0] value,
	output bss_pkg::sts_t                      sts,
	output logic signed [bss_pkg::VALUE_W-1:0] value_res,
	output logic                               last_res,
	output logic [bss_pkg::SWAP_W-1:0]         swap_count,
	output logic                               overflow
);
	import bss_pkg::*;

	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam int PAIRS  = DEPTH - 1;

	logic signed [VALUE_W-1:0] lane_q [DEPTH];
	logic signed [VALUE_W-1:0] lane_d [DEPTH];
	logic [FILL_W-1:0]         fill_q;
	logic [FILL_W-1:0]         phase_q;
	logic                      drop_q;
	logic [SWAP_W-1:0]         swap_q;
	logic [PAIRS-1:0]          swp_s1;
	logic [PAIRS-1:0]          act;
	logic [PAIRS-1:0]          swp;
	logic                      full;

	assign full = (fill_q == FILL_W'(DEPTH));

	// A pair (i, i+1) takes part when its parity matches the phase and both
	// lanes hold elements of the batch.
	always_comb begin
		for (int i = 0; i < PAIRS; i++) begin
			act[i] = cmd.sort && ((i % 2) == int'(phase_q[0])) && (FILL_W'(i + 1) < fill_q);
			swp[i] = act[i] && (lane_q[i] > lane_q[i + 1]);
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			lane_d[i] = lane_q[i];
			if (cmd.load && !full && (fill_q == FILL_W'(i))) begin
				lane_d[i] = value;
			end else if (cmd.shift) begin
				if (i < DEPTH - 1) begin
					lane_d[i] = lane_q[(i + 1) % DEPTH];
				end
			end else begin
				if (i < PAIRS && swp[i % PAIRS]) begin
					lane_d[i] = lane_q[(i + 1) % DEPTH];
				end
				if (i > 0 && swp[(i + PAIRS - 1) % PAIRS]) begin
					lane_d[i] = lane_q[(i + DEPTH - 1) % DEPTH];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			lane_q[i] <= lane_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			phase_q <= '0;
			drop_q  <= 1'b0;
			swap_q  <= '0;
			swp_s1  <= '0;
		end else begin
			swp_s1  <= swp;
			phase_q <= cmd.sort ? phase_q + 1'b1 : '0;
			if (cmd.load) begin
				if (full) begin
					drop_q <= 1'b1;
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end
			// Swaps found in one phase are counted in the following cycle.
			if (cmd.shift && sts.one_left) begin
				fill_q <= '0;
				drop_q <= 1'b0;
				swap_q <= '0;
			end else begin
				if (cmd.shift) begin
					fill_q <= fill_q - 1'b1;
				end
				swap_q <= swap_q + SWAP_W'($countones(swp_s1));
			end
		end
	end

	assign sts.sort_done = ({1'b0, phase_q} + 1'b1) >= {1'b0, fill_q};
	assign sts.one_left  = (fill_q == FILL_W'(1));

	assign value_res  = lane_q[0];
	assign last_res   = sts.one_left;
	assign swap_count = swap_q;
	assign overflow   = drop_q;

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(DEPTH))
		else $error("fill count exceeds the lane count");

	a_sorted_out: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift && fill_q > FILL_W'(1)) |-> !(lane_q[0] > lane_q[1]))
		else $error("emitted element is greater than its successor");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift && !sts.one_left) |=> $stable(swap_q))
		else $error("swap count changed while emitting");

	a_batch_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift && sts.one_left) |=> (fill_q == '0 && !drop_q && swap_q == '0))
		else $error("batch state not cleared after final element");
`endif

endmodule

/* rtl/bss_ctrl.sv */
// ----------------------------------------------------------------------------
// bss_ctrl
// Controller state machine: load, sort phases, count flush and emit.
// ----------------------------------------------------------------------------
module bss_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid,
	input  logic          last,
	input  logic          stall_res,
	input  bss_pkg::sts_t sts,
	output logic          stall,
	output logic          valid_res,
	output bss_pkg::cmd_t cmd
);
	import bss_pkg::*;

	st_t state_q;
	st_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (valid && last) state_d = ST_SORT;
			end
			ST_SORT: begin
				if (sts.sort_done) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!stall_res && sts.one_left) state_d = ST_LOAD;
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_comb begin
		stall     = 1'b1;
		valid_res = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_LOAD: begin
				stall    = 1'b0;
				cmd.load = valid;
			end
			ST_SORT: begin
				cmd.sort = 1'b1;
			end
			ST_FLUSH: begin
			end
			ST_EMIT: begin
				valid_res = 1'b1;
				cmd.shift = !stall_res;
			end
			default: begin
			end
		endcase
	end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the batch sorter: feeds batches of signed values,
// sorts each batch in a local bubble-sort model with swap and drop tracking,
// and compares every sorted output transaction against that model.
// ----------------------------------------------------------------------------
module tb_top;

	import bss_pkg::*;

	localparam int DEPTH = DEPTH_DEF;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} elem_t;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
		logic [SWAP_W-1:0]         swaps;
		logic                      dropped;
	} sorted_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic valid = 1'b0;
	logic stall;
	logic signed [VALUE_W-1:0] value = '0;
	logic last = 1'b0;
	logic valid_res;
	logic stall_res = 1'b0;
	logic signed [VALUE_W-1:0] value_res;
	logic last_res;
	logic [SWAP_W-1:0] swap_count;
	logic overflow;

	elem_t   pending_elems[$];
	sorted_t sorted_due[$];

	// Batch being collected by the model.
	logic signed [VALUE_W-1:0] batch_vals[$];
	logic                      batch_dropped = 1'b0;

	int  mismatches = 0;
	int  results_seen = 0;
	logic in_fired = 1'b0;
	logic calm = 1'b0;
	int  calm_cnt = 0;
	int  send_gap = 0;
	int  hold_left = 0;
	logic pressure_done = 1'b0;

	bubble_sort_swap_counter #(.DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid),
		.stall     (stall),
		.value     (value),
		.last      (last),
		.valid_res (valid_res),
		.stall_res (stall_res),
		.value_res (value_res),
		.last_res  (last_res),
		.swap_count(swap_count),
		.overflow  (overflow)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, a few long ones, none at all during calm stretches.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic push_elem(input logic signed [VALUE_W-1:0] v, input logic l);
		elem_t e;
		e.value = v;
		e.last  = l;
		pending_elems.push_back(e);
	endtask

	// Content styles: random, descending, ascending, narrow range with repeats.
	task automatic queue_batch(input int n, input int style);
		logic signed [VALUE_W-1:0] v;
		int step;
		v    = $urandom;
		step = $urandom_range(1, 1000);
		for (int i = 0; i < n; i++) begin
			case (style)
				0: v = $urandom;
				1: v = (i == 0) ? v : v - step;
				2: v = (i == 0) ? v : v + step;
				default: v = $signed(32'($urandom_range(0, 8))) - 4;
			endcase
			push_elem(v, i == n - 1);
		end
	endtask

	// Model of the block: collect elements, then bubble-sort on the last one.
	task automatic absorb_element(input logic signed [VALUE_W-1:0] v, input logic l);
		logic signed [VALUE_W-1:0] tmp;
		logic [SWAP_W-1:0] swaps;
		sorted_t s;
		int n;
		if (batch_vals.size() < DEPTH)
			batch_vals.push_back(v);
		else
			batch_dropped = 1'b1;
		if (l) begin
			n = batch_vals.size();
			swaps = '0;
			for (int p = 1; p < n; p++) begin
				for (int k = 0; k + p < n; k++) begin
					if (batch_vals[k] > batch_vals[k+1]) begin
						tmp = batch_vals[k];
						batch_vals[k] = batch_vals[k+1];
						batch_vals[k+1] = tmp;
						swaps = swaps + 1'b1;
					end
				end
			end
			for (int k = 0; k < n; k++) begin
				s.value   = batch_vals[k];
				s.last    = (k == n - 1);
				s.swaps   = swaps;
				s.dropped = batch_dropped;
				sorted_due.push_back(s);
			end
			batch_vals.delete();
			batch_dropped = 1'b0;
		end
	endtask

	task automatic check_result();
		sorted_t s;
		results_seen++;
		if (sorted_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected result value=%0d last=%0b swaps=%0d ovf=%0b",
					$realtime, value_res, last_res, swap_count, overflow);
		end else begin
			s = sorted_due.pop_front();
			if (value_res !== s.value || last_res !== s.last ||
			    swap_count !== s.swaps || overflow !== s.dropped) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch exp value=%0d last=%0b swaps=%0d ovf=%0b, got value=%0d last=%0b swaps=%0d ovf=%0b",
						$realtime, s.value, s.last, s.swaps, s.dropped,
						value_res, last_res, swap_count, overflow);
			end
		end
	endtask

	// Monitor: both channels are sampled at the rising edge.
	always @(posedge clk) begin
		in_fired <= arst_n && valid && !stall;
		if (arst_n && valid && !stall)
			absorb_element(value, last);
		if (arst_n && valid_res && !stall_res)
			check_result();
	end

	always @(negedge clk) begin
		if (calm_cnt == 0) begin
			calm <= ($urandom_range(0, 3) == 0);
			calm_cnt <= $urandom_range(40, 160);
		end else begin
			calm_cnt <= calm_cnt - 1;
		end
	end

	// Driver: a held transaction stays on the bus until it is accepted.
	always @(negedge clk) begin
		elem_t e;
		if (arst_n && (!valid || in_fired)) begin
			if (send_gap > 0) begin
				valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_elems.size() > 0) begin
				e = pending_elems.pop_front();
				valid <= 1'b1;
				value <= e.value;
				last <= e.last;
				send_gap <= pick_gap();
			end else begin
				valid <= 1'b0;
			end
		end
	end

	// Receiver stall, with one long hold-off so the block backs up its input.
	always @(negedge clk) begin
		int n;
		if (hold_left > 0) begin
			stall_res <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!pressure_done && results_seen >= 30) begin
			stall_res <= 1'b1;
			hold_left <= 300;
			pressure_done <= 1'b1;
		end else begin
			n = pick_gap();
			stall_res <= (n > 0);
			hold_left <= (n > 0) ? n - 1 : 0;
		end
	end

	initial begin
		int n;
		int r;
		// Directed batches: single elements, a swapped pair, extremes and ties.
		push_elem(32'sh8000_0000, 1'b1);
		push_elem(32'sh7fff_ffff, 1'b1);
		push_elem(32'sh7fff_ffff, 1'b0);
		push_elem(32'sh8000_0000, 1'b1);
		push_elem(32'sd0, 1'b0);
		push_elem(-32'sd1, 1'b0);
		push_elem(-32'sd1, 1'b0);
		push_elem(32'sd5, 1'b0);
		push_elem(32'sh8000_0000, 1'b0);
		push_elem(32'sh7fff_ffff, 1'b0);
		push_elem(32'sd1, 1'b0);
		push_elem(32'sd0, 1'b1);
		push_elem(32'sd3, 1'b0);
		push_elem(32'sd3, 1'b0);
		push_elem(32'sd3, 1'b1);

		// A full descending store gives the largest swap count; the next batch
		// overflows with the last transaction itself dropped.
		queue_batch(DEPTH, 1);
		queue_batch(DEPTH + 1, 0);
		while (pending_elems.size() < 300) begin
			r = $urandom_range(0, 99);
			if (r < 6)
				n = $urandom_range(DEPTH - 1, DEPTH + 4);
			else
				n = $urandom_range(1, 10);
			queue_batch(n, $urandom_range(0, 3));
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_elems.size() > 0 || valid)
			@(posedge clk);
		while (sorted_due.size() > 0)
			@(posedge clk);
		repeat (3 * DEPTH + 10) @(posedge clk);

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

/* files.f */
rtl/bss_pkg.sv
rtl/bss_datapath.sv
rtl/bss_ctrl.sv
rtl/bubble_sort_swap_counter.sv
tb/sv/tb_top.sv
